[rtl/core/rpn_stack_calculator_core_macros.svh]
// Assertion helpers shared by the calculator RTL.
`ifndef RPN_STACK_CALCULATOR_CORE_MACROS_SVH
`define RPN_STACK_CALCULATOR_CORE_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define RPN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/rpn_pkg.sv]
package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 3;

  // Quotient bits produced by the divider when the result does not overflow.
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PRINT = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_ZERO_DIV = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_INVALID  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
  } out_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_RD_B,
    S_GET_B,
    S_RD_A,
    S_GET_A,
    S_EXEC,
    S_MUL_SAT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WR,
    S_OUT
  } state_e;

endpackage

[rtl/core/rpn_div.sv]
// Signed Q16.16 divider: (a * 65536) / b truncated toward zero and saturated.
// Overflow is detected up front, so only 31 restoring steps are ever needed.
module rpn_div
  import rpn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] dividend_i,
  input  logic [VAL_W-1:0] divisor_i,
  output div_rsp_t         rsp_o
);

  logic                 busy_q, fin_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]     rem_q, den_q, quot_q;
  logic [DIV_STEPS-1:0] num_q, quo_q;
  logic                 neg_q, ovf_q;

  logic [VAL_W-1:0]       mag_a, mag_b;
  logic [VAL_W+15:0]      num_full;
  logic [VAL_W-1:0]       num_hi;
  logic                   ovf_start;
  logic [VAL_W:0]         trial, diff;
  logic                   ge;
  logic [VAL_W-1:0]       quo_ext;

  always_comb begin
    mag_a     = dividend_i[VAL_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b     = divisor_i[VAL_W-1] ? (~divisor_i + 1'b1) : divisor_i;
    num_full  = {mag_a, 16'b0};
    // The quotient reaches 2^31 exactly when the dividend bits above bit 30
    // are already no smaller than the divisor.
    num_hi    = VAL_W'(num_full[VAL_W+15:DIV_STEPS]);
    ovf_start = num_hi >= mag_b;
    trial     = {rem_q, num_q[DIV_STEPS-1]};
    diff      = trial - {1'b0, den_q};
    ge        = trial >= {1'b0, den_q};
    quo_ext   = {1'b0, quo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      if (start_i) begin
        busy_q <= !ovf_start;
        fin_q  <= ovf_start;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[VAL_W-1] ^ divisor_i[VAL_W-1];
      ovf_q <= ovf_start;
      den_q <= mag_b;
      rem_q <= num_hi;
      num_q <= num_full[DIV_STEPS-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
      quo_q <= {quo_q[DIV_STEPS-2:0], ge};
    end
    if (fin_q) begin
      if (ovf_q) begin
        quot_q <= neg_q ? Q_MIN : Q_MAX;
      end else begin
        quot_q <= neg_q ? (~quo_ext + 1'b1) : quo_ext;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/core/rpn_stack_calculator_core.sv]
// Channel  | Direction | Handshake                 | Beat payload
// ---------+-----------+---------------------------+------------------------------
// in       | input     | in_valid_i / in_ready_o   | in_t: mode, operand
// out      | output    | out_valid_o / out_ready_i | out_t: value, status
//
// Each item runs through the sequencer states for its mode, and also waits in S_OUT
// until the output register is free. Divide uses the radix-2 divider in rpn_div,
// which runs 31 restoring steps. A divide whose quotient overflows skips those steps
// and saturates, and one with a zero divisor ends without starting the divider.
// Reset clears the stack depth, the control state and the output valid; stack
// contents are left as they are and are only read below the current depth.
// A new beat is taken only when the previous item has left for the output register,
// so one result may wait downstream while the next item is already being worked on.
module rpn_stack_calculator_core
  import rpn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

`include "rpn_stack_calculator_core_macros.svh"

  // Operand stack: a single-port-write, single-port-read synchronous memory.
  logic [VAL_W-1:0] stack_mem [STACK_DEPTH];
  logic [VAL_W-1:0] rdata_q;
  logic             mem_re, mem_we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [VAL_W-1:0] wdata;

  state_e state_q, state_d;

  logic [DEPTH_W-1:0] depth_q, depth_m1;
  logic               empty_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [MODE_W-1:0]  mode_q;
  logic [VAL_W-1:0]   opnd_q, a_q, b_q, res_q;
  logic [STAT_W-1:0]  status_q;
  logic [2*VAL_W-1:0] prod_q;

  logic               in_fire, out_free, depth_zero, stack_full;
  logic [VAL_W-1:0]   pop_val;
  logic [VAL_W:0]     sum;
  logic [VAL_W-1:0]   sum_sat, mul_sat;
  logic               div_start;
  div_rsp_t           div_rsp;

  assign depth_zero = depth_q == '0;
  assign stack_full = depth_q == DEPTH_W'(STACK_DEPTH);
  assign depth_m1   = depth_q - 1'b1;
  // A pop from an empty stack reads as zero.
  assign pop_val    = depth_zero ? '0 : rdata_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Saturating add and subtract on a 33-bit sum; overflow shows as the two
  // top bits disagreeing.
  always_comb begin
    if (mode_q == MODE_SUB) begin
      sum = {a_q[VAL_W-1], a_q} - {b_q[VAL_W-1], b_q};
    end else begin
      sum = {a_q[VAL_W-1], a_q} + {b_q[VAL_W-1], b_q};
    end
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sum_sat = sum[VAL_W] ? Q_MIN : Q_MAX;
    end else begin
      sum_sat = sum[VAL_W-1:0];
    end
  end

  // The product is shifted right by 16 with an arithmetic shift, which floors.
  // It fits when the bits from the sign down to bit 47 all agree.
  always_comb begin
    if (&prod_q[2*VAL_W-1:VAL_W+15] || ~|prod_q[2*VAL_W-1:VAL_W+15]) begin
      mul_sat = prod_q[VAL_W+15:16];
    end else begin
      mul_sat = prod_q[2*VAL_W-1] ? Q_MIN : Q_MAX;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == MODE_PUSH) begin
            state_d = S_PUSH;
          end else if (in_data_i.mode == MODE_ADD || in_data_i.mode == MODE_SUB ||
                       in_data_i.mode == MODE_MUL || in_data_i.mode == MODE_DIV ||
                       in_data_i.mode == MODE_PRINT) begin
            state_d = S_RD_B;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_PUSH:  state_d = S_OUT;
      S_RD_B:  state_d = S_GET_B;
      S_GET_B: begin
        if (mode_q == MODE_PRINT) begin
          state_d = S_OUT;
        end else if (mode_q == MODE_DIV && pop_val == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RD_A;
        end
      end
      S_RD_A:  state_d = S_GET_A;
      S_GET_A: state_d = (mode_q == MODE_DIV) ? S_DIV_GO : S_EXEC;
      S_EXEC:  state_d = (mode_q == MODE_MUL) ? S_MUL_SAT : S_WR;
      S_MUL_SAT: state_d = S_WR;
      S_DIV_GO:  state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_WR;
        end
      end
      S_WR: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer. Reads (S_RD_B, S_RD_A) and writes (S_PUSH, S_WR)
  // are issued in different states, so the memory never needs a bypass.
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    wdata      = res_q;
    unique case (state_q)
      S_IDLE:   in_ready_o = 1'b1;
      S_PUSH: begin
        mem_we = !stack_full;
        wdata  = opnd_q;
      end
      S_RD_B, S_RD_A: mem_re = !depth_zero;
      S_DIV_GO: div_start = 1'b1;
      S_WR:     mem_we = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign raddr = depth_m1[ADDR_W-1:0];
  assign waddr = depth_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= stack_mem[raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        empty_q <= 1'b0;
      end
      if ((state_q == S_GET_B) || (state_q == S_GET_A)) begin
        if (depth_zero) begin
          empty_q <= 1'b1;
        end else begin
          depth_q <= depth_m1;
        end
      end
      if (mem_we) begin
        depth_q <= depth_q + 1'b1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= in_data_i.mode;
      opnd_q   <= in_data_i.operand;
      res_q    <= '0;
      status_q <= STATUS_INVALID;
    end
    unique case (state_q)
      S_PUSH: begin
        res_q    <= opnd_q;
        status_q <= stack_full ? STATUS_FULL : STATUS_OK;
      end
      S_GET_B: begin
        b_q <= pop_val;
        if (mode_q == MODE_DIV && pop_val == '0) begin
          res_q    <= '0;
          status_q <= STATUS_ZERO_DIV;
        end else begin
          res_q    <= pop_val;
          status_q <= (depth_zero || empty_q) ? STATUS_EMPTY : STATUS_OK;
        end
      end
      S_GET_A: a_q <= pop_val;
      S_EXEC: begin
        res_q  <= sum_sat;
        prod_q <= $signed(a_q) * $signed(b_q);
      end
      S_MUL_SAT: res_q <= mul_sat;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_q <= div_rsp.quot;
        end
      end
      S_WR: status_q <= empty_q ? STATUS_EMPTY : STATUS_OK;
      S_OUT: begin
        if (out_free) begin
          out_q.value  <= res_q;
          out_q.status <= status_q;
        end
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .rsp_o      (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The depth can never pass the stack size, and no write lands on a full stack.
  `RPN_ASSERT(a_depth_bound, depth_q <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")
  `RPN_ASSERT(a_write_room, mem_we |-> !stack_full, "write to a full stack")
  // An accepted beat always moves the sequencer out of idle.
  `RPN_ASSERT(a_accept_leaves_idle, in_fire |=> state_q != S_IDLE, "accept did not start work")
  // The divider only reports while the sequencer is waiting for it.
  `RPN_ASSERT(a_div_done_wait, div_rsp.done |-> state_q == S_DIV_WAIT, "stray divider result")

endmodule
